// File: rtl/vital_sign_baseline_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// vital sign baseline tracker assertion macros
// implication checks that can be compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef VITAL_SIGN_BASELINE_TRACKER_UNIT_MACROS_SVH
`define VITAL_SIGN_BASELINE_TRACKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define VSBT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("vsbt check failed");
// next-cycle implication
`define VSBT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("vsbt check failed");
`else
`define VSBT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VSBT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/vsbt_pkg.sv
// ----------------------------------------------------------------------------
// vsbt_pkg
// types, constants and microcode rom of the vital sign baseline tracker
// ----------------------------------------------------------------------------
package vsbt_pkg;

	localparam int VAL_W  = 16;
	localparam int STEP_W = 4;
	localparam int CFG_W  = 2;

	// register indexes
	localparam logic [CFG_W-1:0] REG_STEADY_RATE = 2'd0;
	localparam logic [CFG_W-1:0] REG_SKIP_THRESH = 2'd1;
	localparam logic [CFG_W-1:0] REG_MIN_SAMPLES = 2'd2;

	// register reset values
	localparam logic [VAL_W-1:0] STEADY_RATE_RST = 16'd1311;
	localparam logic [VAL_W-1:0] SKIP_THRESH_RST = 16'd39322;
	localparam logic [VAL_W-1:0] MIN_SAMPLES_RST = 16'd30;

	// baseline reset values, q8.8
	localparam logic [VAL_W-1:0] REST_RST   = 16'd18432;
	localparam logic [VAL_W-1:0] SPREAD_RST = 16'd3072;
	localparam logic [VAL_W-1:0] SPO2_RST   = 16'd24960;
	localparam logic [VAL_W-1:0] TEMP_RST   = 16'd9318;

	localparam logic [VAL_W-1:0] BOOT_RATE    = 16'd9830;
	localparam logic [VAL_W-1:0] SPREAD_FLOOR = 16'd1536;
	localparam logic [VAL_W-1:0] COUNT_MAX    = 16'hFFFF;
	localparam logic [VAL_W:0]   RATE_ONE     = 17'h10000;

	// baseline channels
	localparam logic [1:0] CH_REST   = 2'd0;
	localparam logic [1:0] CH_SPREAD = 2'd1;
	localparam logic [1:0] CH_SPO2   = 2'd2;
	localparam logic [1:0] CH_TEMP   = 2'd3;

	// program addresses
	localparam logic [STEP_W-1:0] ST_CAPTURE = 4'd0;
	localparam logic [STEP_W-1:0] ST_EMIT    = 4'd14;

	typedef struct packed {
		logic             sample_valid;
		logic [VAL_W-1:0] heart_rate;
		logic [VAL_W-1:0] oxygen_sat;
		logic [VAL_W-1:0] body_temp;
		logic [VAL_W-1:0] risk_score;
	} in_item_t;

	typedef struct packed {
		logic             updated;
		logic [VAL_W-1:0] rest_rate;
		logic [VAL_W-1:0] rate_spread;
		logic [VAL_W-1:0] oxygen_base;
		logic [VAL_W-1:0] temp_base;
		logic             is_ready;
	} out_item_t;

	typedef enum logic [1:0] {
		J_NEXT,
		J_WAIT_IN,
		J_SKIP,
		J_WAIT_OUT
	} jump_t;

	typedef struct packed {
		logic              take_in;
		logic              mul_keep;
		logic [1:0]        chan;
		logic              ld_acc;
		logic              wr_avg;
		logic              ld_spread;
		logic              bump_cnt;
		logic              set_rdy;
		logic              emit;
		jump_t             jump;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	typedef struct packed {
		logic in_req;
		logic skip;
		logic out_busy;
	} status_t;

	// microcode rom: one control word per step
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w        = '0;
		w.jump   = J_NEXT;
		w.target = ST_CAPTURE;
		case (step)
			4'd0: begin
				w.take_in = 1'b1;
				w.jump    = J_WAIT_IN;
			end
			4'd1: begin
				w.mul_keep = 1'b1;
				w.chan     = CH_REST;
				w.jump     = J_SKIP;
				w.target   = ST_EMIT;
			end
			4'd2: begin
				w.chan   = CH_REST;
				w.ld_acc = 1'b1;
			end
			4'd3: begin
				w.chan   = CH_REST;
				w.wr_avg = 1'b1;
			end
			4'd4: begin
				w.mul_keep  = 1'b1;
				w.chan      = CH_SPREAD;
				w.ld_spread = 1'b1;
			end
			4'd5: begin
				w.chan   = CH_SPREAD;
				w.ld_acc = 1'b1;
			end
			4'd6: begin
				w.chan   = CH_SPREAD;
				w.wr_avg = 1'b1;
			end
			4'd7: begin
				w.mul_keep = 1'b1;
				w.chan     = CH_SPO2;
			end
			4'd8: begin
				w.chan   = CH_SPO2;
				w.ld_acc = 1'b1;
			end
			4'd9: begin
				w.chan   = CH_SPO2;
				w.wr_avg = 1'b1;
			end
			4'd10: begin
				w.mul_keep = 1'b1;
				w.chan     = CH_TEMP;
			end
			4'd11: begin
				w.chan   = CH_TEMP;
				w.ld_acc = 1'b1;
			end
			4'd12: begin
				w.chan     = CH_TEMP;
				w.wr_avg   = 1'b1;
				w.bump_cnt = 1'b1;
			end
			4'd13: begin
				w.set_rdy = 1'b1;
			end
			4'd14: begin
				w.emit   = 1'b1;
				w.jump   = J_WAIT_OUT;
				w.target = ST_CAPTURE;
			end
			default: begin
				w.jump   = J_WAIT_OUT;
				w.target = ST_CAPTURE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: rtl/vital_sign_baseline_tracker_unit.sv
// ----------------------------------------------------------------------------
// vital_sign_baseline_tracker_unit
// exponential moving baselines of resting heart rate, spread, spo2 and temp
// ----------------------------------------------------------------------------
// each request carries one vital-sign sample and yields exactly one result
// with the baselines after that sample. a sample folded into the baselines
// runs the whole 15-step microprogram in the sequencer rom: one capture step,
// four channels of three steps each on the single shared 16x17 multiplier
// (keep product, take product, write back; the spread sample is formed in the
// first step of its channel and the count is bumped in the last temperature
// step), one ready step and one emit step; the result register loads in the
// emit step. an invalid or skipped sample jumps from the first multiply step
// straight to emit. a new request is taken as soon as the sequencer is back
// at its capture step, even while the previous result still sits in the
// output register; the emit step then waits for as long as that result is
// stalled, which delays both that sample's result and the next request.
// configuration writes are taken at any time but belong to idle periods.
// ----------------------------------------------------------------------------
module vital_sign_baseline_tracker_unit import vsbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// sample request channel
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	// result channel
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	// configuration write port
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_index,
	input  logic [VAL_W-1:0] cfg_data
);

	// control word of the current step
	ctrl_t   ctrl;
	// datapath conditions for the jump logic
	status_t status;

	// requests are only taken at the capture step
	assign in_stall = !ctrl.take_in;

	// step counter and microcode rom
	vsbt_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// baselines, shared multiplier and result register
	vsbt_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status)
	);

endmodule

// File: rtl/vsbt_seq.sv
// ----------------------------------------------------------------------------
// vsbt_seq
// step counter, microcode rom and conditional jumps
// ----------------------------------------------------------------------------
module vsbt_seq import vsbt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output ctrl_t   ctrl
);

	logic [STEP_W-1:0] step_q;
	logic [STEP_W-1:0] step_nxt;
	logic [STEP_W-1:0] step_inc;

	assign ctrl     = ucode(step_q);
	assign step_inc = step_q + 1'b1;

	always_comb begin
		case (ctrl.jump)
			J_NEXT:     step_nxt = step_inc;
			J_WAIT_IN:  step_nxt = status.in_req ? step_inc : step_q;
			J_SKIP:     step_nxt = status.skip ? ctrl.target : step_inc;
			J_WAIT_OUT: step_nxt = status.out_busy ? step_q : ctrl.target;
			default:    step_nxt = ST_CAPTURE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_CAPTURE;
		end else begin
			step_q <= step_nxt;
		end
	end

endmodule

// File: rtl/vsbt_dp.sv
// ----------------------------------------------------------------------------
// vsbt_dp
// baseline datapath: config registers, one shared multiplier, accumulator
// ----------------------------------------------------------------------------
`include "vital_sign_baseline_tracker_unit_macros.svh"

module vsbt_dp import vsbt_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  ctrl_t            ctrl,
	input  logic             in_valid,
	input  in_item_t         in_data,
	input  logic             out_stall,
	output logic             out_valid,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_index,
	input  logic [VAL_W-1:0] cfg_data,
	output status_t          status
);

	logic [VAL_W-1:0] steady_q, skip_thr_q, min_smp_q;
	logic [VAL_W-1:0] rest_q, spread_q, spo2_q, temp_q;
	logic [VAL_W-1:0] count_q;
	logic             ready_q;
	logic [VAL_W-1:0] hr_q, oxy_q, tmp_q, rate_q, sprd_smp_q;
	logic             accept_q;
	logic [VAL_W:0]   acc_q;
	logic [2*VAL_W:0] prod_s1;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             take;
	logic             emit_go;
	logic [VAL_W-1:0] old_op, x_op, mul_a, diff;
	logic [VAL_W:0]   mul_b;
	logic [VAL_W+1:0] sum;
	logic [VAL_W-1:0] sum_sat;

	assign take    = ctrl.take_in && in_valid;
	assign emit_go = ctrl.emit && !(out_valid_q && out_stall);

	assign status.in_req   = in_valid;
	assign status.skip     = !accept_q;
	assign status.out_busy = out_valid_q && out_stall;

	// operand select
	always_comb begin
		case (ctrl.chan)
			CH_REST:   begin old_op = rest_q;   x_op = hr_q;       end
			CH_SPREAD: begin old_op = spread_q; x_op = sprd_smp_q; end
			CH_SPO2:   begin old_op = spo2_q;   x_op = oxy_q;      end
			CH_TEMP:   begin old_op = temp_q;   x_op = tmp_q;      end
			default:   begin old_op = rest_q;   x_op = hr_q;       end
		endcase
	end

	assign mul_a = ctrl.mul_keep ? old_op : x_op;
	assign mul_b = ctrl.mul_keep ? (RATE_ONE - {1'b0, rate_q}) : {1'b0, rate_q};

	// keep term plus take term, clamped
	assign sum     = {1'b0, acc_q} + {2'b00, prod_s1[2*VAL_W-1:VAL_W]};
	assign sum_sat = (sum > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum[VAL_W-1:0];

	// spread sample against the new resting rate
	assign diff = (hr_q >= rest_q) ? (hr_q - rest_q) : (rest_q - hr_q);

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
		if (ctrl.ld_acc) begin
			acc_q <= prod_s1[2*VAL_W:VAL_W];
		end
		if (ctrl.ld_spread) begin
			sprd_smp_q <= (diff < SPREAD_FLOOR) ? SPREAD_FLOOR : diff;
		end
		if (take) begin
			hr_q   <= in_data.heart_rate;
			oxy_q  <= in_data.oxygen_sat;
			tmp_q  <= in_data.body_temp;
			rate_q <= ready_q ? steady_q : BOOT_RATE;
		end
		if (emit_go) begin
			out_q.updated     <= accept_q;
			out_q.rest_rate   <= rest_q;
			out_q.rate_spread <= spread_q;
			out_q.oxygen_base <= spo2_q;
			out_q.temp_base   <= temp_q;
			out_q.is_ready    <= ready_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steady_q    <= STEADY_RATE_RST;
			skip_thr_q  <= SKIP_THRESH_RST;
			min_smp_q   <= MIN_SAMPLES_RST;
			rest_q      <= REST_RST;
			spread_q    <= SPREAD_RST;
			spo2_q      <= SPO2_RST;
			temp_q      <= TEMP_RST;
			count_q     <= '0;
			ready_q     <= 1'b0;
			accept_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEADY_RATE: steady_q   <= cfg_data;
					REG_SKIP_THRESH: skip_thr_q <= cfg_data;
					REG_MIN_SAMPLES: min_smp_q  <= cfg_data;
					default: ;
				endcase
			end
			if (take) begin
				accept_q <= in_data.sample_valid &&
					!(ready_q && (in_data.risk_score >= skip_thr_q));
			end
			if (ctrl.wr_avg) begin
				case (ctrl.chan)
					CH_REST:   rest_q   <= sum_sat;
					CH_SPREAD: spread_q <= sum_sat;
					CH_SPO2:   spo2_q   <= sum_sat;
					CH_TEMP:   temp_q   <= sum_sat;
					default: ;
				endcase
			end
			if (ctrl.bump_cnt && (count_q != COUNT_MAX)) begin
				count_q <= count_q + 1'b1;
			end
			if (ctrl.set_rdy && (count_q >= min_smp_q)) begin
				ready_q <= 1'b1;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`VSBT_ASSERT_NXT(a_ready_sticks, clk, arst_n, ready_q, ready_q)
	`VSBT_ASSERT_NXT(a_count_sat, clk, arst_n, count_q == COUNT_MAX, count_q == COUNT_MAX)
	`VSBT_ASSERT_NXT(a_avg_only_on_write, clk, arst_n, !ctrl.wr_avg,
		$stable(rest_q) && $stable(spread_q) && $stable(spo2_q) && $stable(temp_q))
	`VSBT_ASSERT_IMP(a_out_load_from_emit, clk, arst_n, $rose(out_valid_q), $past(ctrl.emit))
	`VSBT_ASSERT_IMP(a_no_update_on_skip, clk, arst_n, ctrl.wr_avg || ctrl.bump_cnt, accept_q)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vital sign baseline tracker testbench
// drives samples through the valid/stall channels and predicts every result
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own copy of the four moving baselines, the
// sample count, the ready flag and the three registers. each accepted
// request is folded into that copy unless it is invalid or skipped, and the
// expected result is queued; each accepted result is checked field by field
// against the oldest entry. the run walks through the boot phase, the
// switch to ready, the register extremes and several random settings, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
import vsbt_pkg::*;

class baseline_scoreboard;
	logic [VAL_W-1:0] steady_rate, skip_thresh, min_samples;
	logic [VAL_W-1:0] rest_hr, hr_spread, spo2_avg, temp_avg, accepted;
	logic             ready;
	out_item_t        expected_baselines[$];
	int               mismatches, reported, results_seen, folded, ignored;

	function new();
		steady_rate = STEADY_RATE_RST;
		skip_thresh = SKIP_THRESH_RST;
		min_samples = MIN_SAMPLES_RST;
		rest_hr     = REST_RST;
		hr_spread   = SPREAD_RST;
		spo2_avg    = SPO2_RST;
		temp_avg    = TEMP_RST;
		accepted    = '0;
		ready       = 1'b0;
	endfunction

	function void write_reg(logic [CFG_W-1:0] idx, logic [VAL_W-1:0] v);
		if (idx == REG_STEADY_RATE) steady_rate = v;
		else if (idx == REG_SKIP_THRESH) skip_thresh = v;
		else if (idx == REG_MIN_SAMPLES) min_samples = v;
	endfunction

	// old*(1-r) + x*r, each product truncated on its own
	function logic [VAL_W-1:0] blend(logic [VAL_W-1:0] prev, logic [VAL_W-1:0] x,
			logic [VAL_W:0] rate);
		longint unsigned keep, take, sum;
		keep = (longint'(prev) * (longint'(RATE_ONE) - longint'(rate))) >> 16;
		take = (longint'(x) * longint'(rate)) >> 16;
		sum  = keep + take;
		if (sum > 65535) sum = 65535;
		return sum[VAL_W-1:0];
	endfunction

	function void note_sample(in_item_t s);
		out_item_t        e;
		logic [VAL_W:0]   rate;
		logic [VAL_W-1:0] dev;
		e = '0;
		if (s.sample_valid && !(ready && s.risk_score >= skip_thresh)) begin
			rate    = ready ? {1'b0, steady_rate} : {1'b0, BOOT_RATE};
			rest_hr = blend(rest_hr, s.heart_rate, rate);
			// spread is taken against the freshly updated resting rate
			dev = (s.heart_rate >= rest_hr) ? s.heart_rate - rest_hr
				: rest_hr - s.heart_rate;
			if (dev < SPREAD_FLOOR) dev = SPREAD_FLOOR;
			hr_spread = blend(hr_spread, dev, rate);
			spo2_avg  = blend(spo2_avg, s.oxygen_sat, rate);
			temp_avg  = blend(temp_avg, s.body_temp, rate);
			if (accepted != COUNT_MAX) accepted = accepted + 1'b1;
			if (accepted >= min_samples) ready = 1'b1;
			e.updated = 1'b1;
			folded++;
		end else begin
			ignored++;
		end
		e.rest_rate   = rest_hr;
		e.rate_spread = hr_spread;
		e.oxygen_base = spo2_avg;
		e.temp_base   = temp_avg;
		e.is_ready    = ready;
		expected_baselines.push_back(e);
	endfunction

	function void compare_field(string name, logic [VAL_W-1:0] e, logic [VAL_W-1:0] a);
		if (a !== e) begin
			mismatches++;
			reported++;
			if (reported <= 60)
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
		end
	endfunction

	function void check_result(out_item_t got);
		out_item_t e;
		results_seen++;
		if (expected_baselines.size() == 0) begin
			mismatches++;
			reported++;
			if (reported <= 60)
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			return;
		end
		e = expected_baselines.pop_front();
		compare_field("updated", {15'b0, e.updated}, {15'b0, got.updated});
		compare_field("rest_rate", e.rest_rate, got.rest_rate);
		compare_field("rate_spread", e.rate_spread, got.rate_spread);
		compare_field("oxygen_base", e.oxygen_base, got.oxygen_base);
		compare_field("temp_base", e.temp_base, got.temp_base);
		compare_field("is_ready", {15'b0, e.is_ready}, {15'b0, got.is_ready});
	endfunction

	function int pending();
		return expected_baselines.size();
	endfunction
endclass

module testbench;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_data   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_data;
	logic             cfg_we    = 1'b0;
	logic [CFG_W-1:0] cfg_index = REG_STEADY_RATE;
	logic [VAL_W-1:0] cfg_data  = '0;

	baseline_scoreboard sb;
	bit idle_on   = 1'b1;   // random gaps and stalls enabled
	int reg_writes;

	// output-side stall pattern state
	bit stalling  = 1'b0;
	int run_left  = 0;

	vital_sign_baseline_tracker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// result side: random stall bursts between quiet stretches
	always @(negedge clk) begin
		if (run_left == 0) begin
			stalling = !stalling && ($urandom_range(0, 1) == 0);
			run_left = stalling ? $urandom_range(1, 18) : $urandom_range(1, 40);
		end
		run_left--;
		out_stall <= idle_on && stalling;
	end

	// every accepted result goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall)
			sb.check_result(out_data);
	end

	// hard stop, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic in_item_t mk(logic v, logic [VAL_W-1:0] hr, logic [VAL_W-1:0] ox,
			logic [VAL_W-1:0] tp, logic [VAL_W-1:0] rk);
		in_item_t s;
		s.sample_valid = v;
		s.heart_rate   = hr;
		s.oxygen_sat   = ox;
		s.body_temp    = tp;
		s.risk_score   = rk;
		return s;
	endfunction

	// mostly physiological values, some full-range noise and some rail values
	function automatic logic [VAL_W-1:0] pick_val(int lo, int hi);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6) return 16'($urandom_range(lo, hi));
		else if (sel < 9) return 16'($urandom);
		else return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
	endfunction

	// risk is often steered onto the skip threshold and its neighbors
	function automatic logic [VAL_W-1:0] pick_risk();
		int t;
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: begin
				t = int'(sb.skip_thresh) + $urandom_range(0, 2) - 1;
				if (t < 0) t = 0;
				if (t > 65535) t = 65535;
				return t[VAL_W-1:0];
			end
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(0, int'(sb.skip_thresh)));
		endcase
	endfunction

	function automatic in_item_t random_sample();
		// hr 40..180 bpm, spo2 85..100 %, temp 34..41 C, all q8.8
		return mk($urandom_range(0, 9) != 0, pick_val(10240, 46080),
			pick_val(21760, 25600), pick_val(8704, 10496), pick_risk());
	endfunction

	// one request: optional idle gap, then hold valid until accepted
	task automatic send_sample(in_item_t s);
		int gap;
		gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_sample(s);
	endtask

	// sender holds off until every queued result has come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_W-1:0] idx, logic [VAL_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.write_reg(idx, v);
		reg_writes++;
	endtask

	// registers change only with the pipeline empty
	task automatic configure(logic [VAL_W-1:0] rate, logic [VAL_W-1:0] thresh,
			logic [VAL_W-1:0] needed);
		drain();
		write_reg(REG_STEADY_RATE, rate);
		write_reg(REG_SKIP_THRESH, thresh);
		write_reg(REG_MIN_SAMPLES, needed);
	endtask

	task automatic run_samples(int n);
		for (int i = 0; i < n; i++) begin
			send_sample(random_sample());
			// occasional full stop of the sender mid-phase
			if ($urandom_range(0, 99) == 0) drain();
		end
	endtask

	initial begin
		in_item_t directed[$];
		sb = new();
		reg_writes = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// boot phase at reset register values: boot rate, risk never checked
		directed.push_back(mk(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // invalid
		directed.push_back(mk(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000)); // invalid
		directed.push_back(mk(1'b1, 16'd18432, 16'd24960, 16'd9318, 16'h0000)); // spread floor
		directed.push_back(mk(1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
		directed.push_back(mk(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)); // max risk, not ready
		directed.push_back(mk(1'b1, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
		directed.push_back(mk(1'b1, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
		directed.push_back(mk(1'b0, 16'h1234, 16'h4321, 16'h00FF, 16'h0001));
		directed.push_back(mk(1'b1, 16'd19000, 16'd25000, 16'd9400, 16'd39322));
		directed.push_back(mk(1'b1, 16'd20000, 16'd24000, 16'd9500, 16'd39321));
		directed.push_back(mk(1'b1, 16'd45000, 16'd21800, 16'd10400, 16'd60000));
		directed.push_back(mk(1'b1, 16'd10300, 16'd25500, 16'd8800, 16'd100));
		directed.push_back(mk(1'b1, 16'd18500, 16'd24900, 16'd9300, 16'd0));
		directed.push_back(mk(1'b1, 16'd18600, 16'd24950, 16'd9320, 16'd0));
		directed.push_back(mk(1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000));
		directed.push_back(mk(1'b1, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF));
		directed.push_back(mk(1'b1, 16'd18432, 16'd24960, 16'd9318, 16'd32768));
		directed.push_back(mk(1'b0, 16'd30000, 16'd20000, 16'd9000, 16'd0));
		foreach (directed[i]) send_sample(directed[i]);

		// still booting with the other registers at their extremes: count never
		// reaches the threshold and a zero skip threshold must not matter
		configure(16'd0, 16'd0, 16'hFFFF);
		run_samples(180);

		// threshold dropped below the count: next accepted sample makes it ready
		configure(16'hFFFF, 16'hFFFF, 16'd0);
		send_sample(mk(1'b1, 16'd18000, 16'd24800, 16'd9300, 16'd0));
		run_samples(200);

		// zero rate freezes the baselines while samples still count
		configure(16'd0, 16'd40000, 16'd0);
		run_samples(150);

		// zero skip threshold rejects every sample once ready
		configure(16'd1311, 16'd0, 16'd5);
		run_samples(100);

		// random settings, mostly small learning rates
		for (int p = 0; p < 5; p++) begin
			configure(($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000)),
				16'($urandom), 16'($urandom));
			run_samples(150);
		end

		// last stretch at reset values, without gaps or stalls
		configure(STEADY_RATE_RST, SKIP_THRESH_RST, MIN_SAMPLES_RST);
		idle_on = 1'b0;
		run_samples(150);

		drain();
		// any result beyond the queued ones shows up as unexpected
		repeat (40) @(posedge clk);

		$display("covered %0d samples: %0d folded into the baselines, %0d ignored",
			sb.folded + sb.ignored, sb.folded, sb.ignored);
		$display("%0d results checked across %0d register writes, ready=%0b count=%0d",
			sb.results_seen, reg_writes, sb.ready, sb.accepted);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
